[rtl/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ssrc_pkg.sv]
// ----------------------------------------------------------------------------
// ssrc_pkg
// Shared types, constants and coefficient table of the stepper ramp controller.
// ----------------------------------------------------------------------------
package ssrc_pkg;

	localparam int FREQ_W   = 20;
	localparam int ERR_W    = 21;
	localparam int STEP_W   = 16;
	localparam int RELOAD_W = 16;
	localparam int RPM_W    = 14;
	localparam int CFG_W    = 21;
	localparam int IDX_W    = 3;
	localparam int HIST_W   = 32;

	localparam int DEF_HISTORY_DEPTH = 4;
	localparam int DEF_TIMER_HZ      = 3000000;

	localparam logic [FREQ_W-1:0] DEF_MIN_FREQ = 20'd1000;
	localparam logic [FREQ_W-1:0] DEF_MAX_FREQ = 20'd20000;
	localparam logic [ERR_W-1:0]  DEF_ERR_HIGH = 21'sd2000;
	localparam logic [ERR_W-1:0]  DEF_ERR_LOW  = -21'sd2000;
	localparam logic [STEP_W-1:0] DEF_DECEL    = 16'd100;

	localparam logic [IDX_W-1:0] REG_MIN_FREQ = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_FREQ = 3'd1;
	localparam logic [IDX_W-1:0] REG_ERR_HIGH = 3'd2;
	localparam logic [IDX_W-1:0] REG_ERR_LOW  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DECEL    = 3'd4;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_ACCEL = 2'd1;
	localparam logic [1:0] OP_DECEL = 2'd2;
	localparam logic [1:0] OP_DIR   = 2'd3;

	localparam logic [FREQ_W-1:0] END_MARGIN = 20'd75;
	localparam int                RPM_MUL_W  = 22;
	localparam logic [1:0]        RPM_DIV    = 2'd3;

	// serial multiply-accumulate sizing
	localparam int MAC_MW = 40;
	localparam int MAC_AW = 56;
	localparam int MAC_CW = 16;
	localparam int TERM_W = 4;
	localparam logic [TERM_W-1:0] LAST_TERM = 4'd8;
	localparam logic [MAC_CW-1:0] C_GAIN    = 16'd3886;

	typedef enum logic [1:0] {MODE_IDLE, MODE_ACCEL, MODE_DECEL} mode_t;
	typedef enum logic [1:0] {SRC_DRIVE, SRC_ERROR, SRC_SAMPLE} src_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic neg;
	} mac_cmd_t;

	typedef struct packed {
		logic [MAC_CW-1:0] coef;
		logic              neg;
		src_t              src;
		logic [2:0]        back;
	} term_t;

	function automatic term_t term_info(input logic [TERM_W-1:0] k);
		term_t t;
		t = '{coef: 16'd0, neg: 1'b0, src: SRC_SAMPLE, back: 3'd0};
		case (k)
			4'd0: t = '{coef: 16'd16384, neg: 1'b1, src: SRC_DRIVE, back: 3'd4};
			4'd1: t = '{coef: 16'd6165,  neg: 1'b0, src: SRC_DRIVE, back: 3'd3};
			4'd2: t = '{coef: 16'd13936, neg: 1'b0, src: SRC_DRIVE, back: 3'd2};
			4'd3: t = '{coef: 16'd169,   neg: 1'b0, src: SRC_DRIVE, back: 3'd1};
			4'd4: t = '{coef: 16'd36269, neg: 1'b0, src: SRC_ERROR, back: 3'd4};
			4'd5: t = '{coef: 16'd44293, neg: 1'b1, src: SRC_ERROR, back: 3'd3};
			4'd6: t = '{coef: 16'd24081, neg: 1'b1, src: SRC_ERROR, back: 3'd2};
			4'd7: t = '{coef: 16'd44340, neg: 1'b0, src: SRC_ERROR, back: 3'd1};
			4'd8: t = '{coef: 16'd10895, neg: 1'b1, src: SRC_SAMPLE, back: 3'd0};
			default: t = '{coef: 16'd0, neg: 1'b0, src: SRC_SAMPLE, back: 3'd0};
		endcase
		return t;
	endfunction

endpackage

[rtl/stepper_speed_ramp_controller.sv]
// ----------------------------------------------------------------------------
// stepper_speed_ramp_controller
// Step-rate ramp controller: commands, fourth-order IIR acceleration,
// linear deceleration, timer reload by serial division.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// in      | in_valid / in_stall | operation, target_rpm, dir_right
// out     | out_valid/out_stall | timer_reload, pwm_enable, direction_pin,
//         |                     | ramp_done, step_freq
// cfg     | wr_en               | wr_index, wr_data
//
// One transaction at a time. Direction and idle ticks go straight to output.
// Ramp commands convert the target rpm in the serial divider. Acceleration
// ticks run the bit-serial MAC (9 terms plus gain, one coefficient bit per
// cycle), deceleration ticks subtract the step; a nonzero new rate then gets
// its timer reload from the divider. A finished result waits in the output
// register while the next transaction is taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
module stepper_speed_ramp_controller #(
	parameter int HISTORY_DEPTH  = ssrc_pkg::DEF_HISTORY_DEPTH,
	parameter int TIMER_CLOCK_HZ = ssrc_pkg::DEF_TIMER_HZ
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     operation,
	input  logic [ssrc_pkg::RPM_W-1:0]     target_rpm,
	input  logic                           dir_right,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ssrc_pkg::RELOAD_W-1:0]  timer_reload,
	output logic                           pwm_enable,
	output logic                           direction_pin,
	output logic                           ramp_done,
	output logic [ssrc_pkg::FREQ_W-1:0]    step_freq,
	input  logic                           wr_en,
	input  logic [ssrc_pkg::IDX_W-1:0]     wr_index,
	input  logic [ssrc_pkg::CFG_W-1:0]     wr_data
);

	`include "assert_macros.svh"

	localparam int PW  = $clog2(HISTORY_DEPTH);
	localparam int TW  = $clog2(TIMER_CLOCK_HZ + 1);
	localparam int NW  = (TW > ssrc_pkg::RPM_MUL_W) ? TW : ssrc_pkg::RPM_MUL_W;
	localparam int FW  = ssrc_pkg::FREQ_W;
	localparam int HW  = ssrc_pkg::HIST_W;
	localparam int MW  = ssrc_pkg::MAC_MW;
	localparam int AW  = ssrc_pkg::MAC_AW;
	localparam int RW  = ssrc_pkg::RELOAD_W;
	localparam logic [PW-1:0] PTR_LAST = PW'(HISTORY_DEPTH - 1);

	typedef enum logic [9:0] {
		S_IDLE       = 10'b0000000001,
		S_CONV_WAIT  = 10'b0000000010,
		S_TERM       = 10'b0000000100,
		S_TERM_WAIT  = 10'b0000001000,
		S_GAIN       = 10'b0000010000,
		S_GAIN_WAIT  = 10'b0000100000,
		S_UPDATE     = 10'b0001000000,
		S_RECIP      = 10'b0010000000,
		S_RECIP_WAIT = 10'b0100000000,
		S_OUT        = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [FW-1:0]                    min_q, max_q;
	logic signed [ssrc_pkg::ERR_W-1:0] ehi_q, elo_q;
	logic [ssrc_pkg::STEP_W-1:0]       dstep_q;

	// ramp state
	logic [RW-1:0]           reload_q;
	logic [FW-1:0]           cur_q, tgt_q;
	ssrc_pkg::mode_t         mode_q;
	logic                    stop_q, pwm_q, dir_q;
	logic [PW-1:0]           ptr_q;
	logic signed [HW-1:0]    drv_hist_q [HISTORY_DEPTH];
	logic signed [HW-1:0]    err_hist_q [HISTORY_DEPTH];

	// transaction
	logic [1:0]                 op_q;
	logic [ssrc_pkg::RPM_W-1:0] rpm_q;
	logic [ssrc_pkg::TERM_W-1:0] term_q;
	logic signed [HW-1:0]       e12_q;

	// output register
	logic          out_valid_q;
	logic [RW-1:0] out_reload_q;
	logic          out_pwm_q, out_dir_q, out_done_q;
	logic [FW-1:0] out_freq_q;

	logic in_accept;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	// error sample
	logic signed [FW+1:0] err_raw, err_c1, err_c2, ehi_x, elo_x;
	logic signed [FW+13:0] err_sh;
	logic signed [HW-1:0] e12_next;
	always_comb begin
		ehi_x   = (FW+2)'(ehi_q);
		elo_x   = (FW+2)'(elo_q);
		err_raw = $signed({2'b00, tgt_q}) - $signed({2'b00, cur_q});
		err_c1  = (err_raw > ehi_x) ? ehi_x : err_raw;
		err_c2  = (err_c1 < elo_x) ? elo_x : err_c1;
		err_sh  = (FW+14)'(err_c2) <<< 12;
		if (err_sh > (FW+14)'(64'sh7FFFFFFF)) begin
			e12_next = 32'sh7FFFFFFF;
		end else if (err_sh < -(FW+14)'(64'sh80000000)) begin
			e12_next = 32'sh80000000;
		end else begin
			e12_next = err_sh[HW-1:0];
		end
	end

	// term operand selection
	ssrc_pkg::term_t      term;
	logic [PW:0]          idx_sum;
	logic [PW-1:0]        idx;
	logic signed [HW-1:0] hval;
	always_comb begin
		term    = ssrc_pkg::term_info(term_q);
		idx_sum = {1'b0, ptr_q} + (PW+1)'(HISTORY_DEPTH) - (PW+1)'(term.back);
		if (idx_sum >= (PW+1)'(HISTORY_DEPTH)) begin
			idx = PW'(idx_sum - (PW+1)'(HISTORY_DEPTH));
		end else begin
			idx = idx_sum[PW-1:0];
		end
		case (term.src)
			ssrc_pkg::SRC_DRIVE: hval = drv_hist_q[idx];
			ssrc_pkg::SRC_ERROR: hval = err_hist_q[idx];
			default:             hval = e12_q;
		endcase
	end

	// MAC
	ssrc_pkg::mac_cmd_t   mac_cmd;
	logic signed [MW-1:0] mac_mcand;
	logic [ssrc_pkg::MAC_CW-1:0] mac_coef;
	logic                 mac_busy;
	logic signed [AW-1:0] mac_acc, mac_bias;
	always_comb begin
		mac_bias = mac_acc + (mac_acc[AW-1] ? AW'(16383) : AW'(0));
		mac_cmd  = '{load: 1'b0, clr: 1'b0, neg: 1'b0};
		mac_mcand = MW'(hval);
		mac_coef  = term.coef;
		if (state_q == S_TERM) begin
			mac_cmd = '{load: 1'b1, clr: (term_q == '0), neg: term.neg};
		end else if (state_q == S_GAIN) begin
			mac_cmd   = '{load: 1'b1, clr: 1'b1, neg: 1'b0};
			mac_mcand = mac_bias[MW+13:14];
			mac_coef  = ssrc_pkg::C_GAIN;
		end
	end

	ssrc_mac #(.MW(MW), .AW(AW), .CW(ssrc_pkg::MAC_CW)) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (mac_cmd),
		.mcand (mac_mcand),
		.coef  (mac_coef),
		.busy  (mac_busy),
		.acc   (mac_acc)
	);

	// divider
	logic          div_start, div_busy;
	logic [NW-1:0] div_num, div_q;
	logic [FW-1:0] div_den;
	logic [ssrc_pkg::RPM_MUL_W-1:0] rpm_x160;
	assign rpm_x160  = (ssrc_pkg::RPM_MUL_W'(target_rpm) << 7)
	                 + (ssrc_pkg::RPM_MUL_W'(target_rpm) << 5);
	assign div_start = (in_accept
	                    && (operation inside {ssrc_pkg::OP_ACCEL, ssrc_pkg::OP_DECEL}))
	                 || (state_q == S_RECIP);
	assign div_num   = (state_q == S_RECIP) ? NW'(TIMER_CLOCK_HZ) : NW'(rpm_x160);
	assign div_den   = (state_q == S_RECIP) ? cur_q : FW'(ssrc_pkg::RPM_DIV);

	ssrc_div #(.NW(NW), .DW(FW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_den),
		.busy    (div_busy),
		.quotient(div_q)
	);

	// command targets
	logic [FW-1:0] conv, acc_tgt, dec_tgt;
	logic          dec_stop;
	always_comb begin
		conv = div_q[FW-1:0];
		if (div_q > NW'(max_q)) begin
			acc_tgt = max_q;
		end else if (div_q < NW'(min_q)) begin
			acc_tgt = min_q;
		end else begin
			acc_tgt = conv;
		end
		dec_stop = (rpm_q == '0);
		dec_tgt  = dec_stop ? min_q : conv;
	end

	// accel update
	logic signed [AW-15:0] g14;
	logic signed [HW-1:0]  u12;
	logic signed [HW:0]    u_bias;
	logic signed [HW-12:0] du;
	logic signed [FW+2:0]  fa;
	logic [FW-1:0]         f_acc;
	always_comb begin
		g14 = mac_bias[AW-1:14];
		if (g14 > (AW-14)'(64'sh7FFFFFFF)) begin
			u12 = 32'sh7FFFFFFF;
		end else if (g14 < -(AW-14)'(64'sh80000000)) begin
			u12 = 32'sh80000000;
		end else begin
			u12 = g14[HW-1:0];
		end
		u_bias = (HW+1)'(u12) + (u12[HW-1] ? (HW+1)'(4095) : (HW+1)'(0));
		du     = u_bias[HW:12];
		fa     = $signed({3'b000, cur_q}) + (FW+3)'(du);
		if (fa < $signed({3'b000, min_q})) begin
			fa = $signed({3'b000, min_q});
		end
		if (fa > $signed({3'b000, tgt_q})) begin
			fa = $signed({3'b000, tgt_q});
		end
		if (fa < 0) begin
			fa = '0;
		end
		f_acc = fa[FW-1:0];
	end

	// decel update
	logic signed [FW:0] fd;
	logic [FW-1:0]      f_dec;
	always_comb begin
		fd = $signed({1'b0, cur_q}) - $signed((FW+1)'(dstep_q));
		f_dec = (fd < $signed({1'b0, tgt_q})) ? tgt_q : fd[FW-1:0];
	end

	logic [FW-1:0] f_new;
	assign f_new = (mode_q == ssrc_pkg::MODE_ACCEL) ? f_acc : f_dec;

	logic [RW-1:0] reload_new;
	always_comb begin
		if (div_q == '0) begin
			reload_new = '0;
		end else if ((div_q - 1'b1) > NW'(16'hFFFF)) begin
			reload_new = '1;
		end else begin
			reload_new = RW'(div_q - 1'b1);
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= ssrc_pkg::DEF_MIN_FREQ;
			max_q   <= ssrc_pkg::DEF_MAX_FREQ;
			ehi_q   <= ssrc_pkg::DEF_ERR_HIGH;
			elo_q   <= ssrc_pkg::DEF_ERR_LOW;
			dstep_q <= ssrc_pkg::DEF_DECEL;
		end else if (wr_en) begin
			case (wr_index)
				ssrc_pkg::REG_MIN_FREQ: min_q   <= wr_data[FW-1:0];
				ssrc_pkg::REG_MAX_FREQ: max_q   <= wr_data[FW-1:0];
				ssrc_pkg::REG_ERR_HIGH: ehi_q   <= wr_data;
				ssrc_pkg::REG_ERR_LOW:  elo_q   <= wr_data;
				ssrc_pkg::REG_DECEL:    dstep_q <= wr_data[ssrc_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			reload_q <= '1;
			cur_q    <= '0;
			tgt_q    <= '0;
			mode_q   <= ssrc_pkg::MODE_IDLE;
			stop_q   <= 1'b0;
			pwm_q    <= 1'b0;
			dir_q    <= 1'b0;
			ptr_q    <= '0;
			term_q   <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				drv_hist_q[i] <= '0;
				err_hist_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						case (operation)
							ssrc_pkg::OP_TICK: begin
								case (mode_q)
									ssrc_pkg::MODE_ACCEL: begin
										term_q  <= '0;
										state_q <= S_TERM;
									end
									ssrc_pkg::MODE_DECEL: state_q <= S_UPDATE;
									default:              state_q <= S_OUT;
								endcase
							end
							ssrc_pkg::OP_DIR: begin
								dir_q   <= dir_right;
								state_q <= S_OUT;
							end
							default: state_q <= S_CONV_WAIT;
						endcase
					end
				end
				S_CONV_WAIT: begin
					if (!div_busy) begin
						if (op_q == ssrc_pkg::OP_ACCEL) begin
							tgt_q  <= acc_tgt;
							stop_q <= 1'b0;
							pwm_q  <= 1'b1;
							mode_q <= ((FW+1)'(cur_q) + (FW+1)'(ssrc_pkg::END_MARGIN)
							           < (FW+1)'(acc_tgt))
							          ? ssrc_pkg::MODE_ACCEL : ssrc_pkg::MODE_IDLE;
						end else begin
							tgt_q  <= dec_tgt;
							stop_q <= dec_stop;
							if (cur_q > dec_tgt) begin
								mode_q <= ssrc_pkg::MODE_DECEL;
							end else begin
								mode_q <= ssrc_pkg::MODE_IDLE;
								if (dec_stop) begin
									pwm_q <= 1'b0;
								end
							end
						end
						state_q <= S_OUT;
					end
				end
				S_TERM: state_q <= S_TERM_WAIT;
				S_TERM_WAIT: begin
					if (!mac_busy) begin
						if (term_q == ssrc_pkg::LAST_TERM) begin
							state_q <= S_GAIN;
						end else begin
							term_q  <= term_q + 1'b1;
							state_q <= S_TERM;
						end
					end
				end
				S_GAIN: state_q <= S_GAIN_WAIT;
				S_GAIN_WAIT: begin
					if (!mac_busy) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					cur_q <= f_new;
					if (mode_q == ssrc_pkg::MODE_ACCEL) begin
						drv_hist_q[ptr_q] <= u12;
						err_hist_q[ptr_q] <= e12_q;
						ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
						if ((FW+1)'(f_new) + (FW+1)'(ssrc_pkg::END_MARGIN)
						    >= (FW+1)'(tgt_q)) begin
							mode_q <= ssrc_pkg::MODE_IDLE;
						end
					end else if (f_new <= tgt_q) begin
						mode_q <= ssrc_pkg::MODE_IDLE;
						if (stop_q) begin
							pwm_q <= 1'b0;
						end
					end
					if (f_new == '0) begin
						reload_q <= '1;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_RECIP;
					end
				end
				S_RECIP: state_q <= S_RECIP_WAIT;
				S_RECIP_WAIT: begin
					if (!div_busy) begin
						reload_q <= reload_new;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= operation;
			rpm_q <= target_rpm;
			e12_q <= e12_next;
		end
	end

	// output register
	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_reload_q <= reload_q;
			out_pwm_q    <= pwm_q;
			out_dir_q    <= dir_q;
			out_done_q   <= (mode_q == ssrc_pkg::MODE_IDLE);
			out_freq_q   <= cur_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign timer_reload  = out_reload_q;
	assign pwm_enable    = out_pwm_q;
	assign direction_pin = out_dir_q;
	assign ramp_done     = out_done_q;
	assign step_freq     = out_freq_q;

	`ASSERT_ALWAYS(a_state_onehot, $onehot(state_q), "sequencer state not one-hot")
	`ASSERT_IMPLY(a_accel_pwm, mode_q == ssrc_pkg::MODE_ACCEL, pwm_q, "accelerating with PWM off")
	`ASSERT_IMPLY(a_accel_below, mode_q == ssrc_pkg::MODE_ACCEL, cur_q < tgt_q, "accel past target")
	`ASSERT_NEXT(a_out_follows, out_load, out_valid_q && state_q == S_IDLE, "result not posted")

endmodule

[rtl/ssrc_mac.sv]
// ----------------------------------------------------------------------------
// ssrc_mac
// Bit-serial multiply-accumulate: one coefficient bit per cycle, shift and add.
// ----------------------------------------------------------------------------
module ssrc_mac #(
	parameter int MW = ssrc_pkg::MAC_MW,
	parameter int AW = ssrc_pkg::MAC_AW,
	parameter int CW = ssrc_pkg::MAC_CW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssrc_pkg::mac_cmd_t   cmd,
	input  logic signed [MW-1:0] mcand,
	input  logic [CW-1:0]        coef,
	output logic                 busy,
	output logic signed [AW-1:0] acc
);

	logic [CW-1:0]        coef_q;
	logic signed [AW-1:0] mcand_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] mcand_ext;

	assign mcand_ext = {{(AW-MW){mcand[MW-1]}}, mcand};
	assign busy      = (coef_q != '0);
	assign acc       = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cmd.load) begin
			coef_q <= coef;
		end else if (busy) begin
			coef_q <= coef_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mcand_q <= cmd.neg ? -mcand_ext : mcand_ext;
			if (cmd.clr) begin
				acc_q <= '0;
			end
		end else if (busy) begin
			if (coef_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q <<< 1;
		end
	end

endmodule

[rtl/ssrc_div.sv]
// ----------------------------------------------------------------------------
// ssrc_div
// Restoring divider, one quotient bit per cycle; quotient shifts into the
// dividend register.
// ----------------------------------------------------------------------------
module ssrc_div #(
	parameter int NW = ssrc_pkg::RPM_MUL_W,
	parameter int DW = ssrc_pkg::FREQ_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dsr_q;
	logic [DW:0]      trial;
	logic             fits;

	assign busy     = (cnt_q != '0);
	assign quotient = num_q;
	assign trial    = {rem_q, num_q[NW-1]};
	assign fits     = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end

endmodule
